// ----- rtl/cse_pkg.sv -----
// cse_pkg.sv: widths, codes and transaction types of the cubic spline evaluator.
// No dependencies; every module of the block imports it.
package cse_pkg;

  localparam int T_BITS    = 16;              // fraction bits of t
  localparam int T_W       = T_BITS + 1;      // t runs up to just below 2.0
  localparam int PT_W      = 64;              // one packed control point
  localparam int CRD_W     = 32;              // one coordinate
  localparam int CW        = CRD_W + 4;       // polynomial coefficient
  localparam int VW        = CRD_W + 9;       // Horner accumulator
  localparam int LO_W      = 24;              // low slice of the split multiply
  localparam int HI_W      = VW - LO_W;
  localparam int NUM_CELLS = 3;               // one Horner step per cell
  localparam int DIV_SPLIT = 24;              // even split for the divide by three
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TYPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_P0   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_P1   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_P2   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_P3   = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    SPL_BEZIER  = 2'd0,
    SPL_HERMITE = 2'd1,
    SPL_CATMULL = 2'd2,
    SPL_BSPLINE = 2'd3
  } spline_t;

  typedef enum logic [1:0] {
    CMD_POS = 2'd0,
    CMD_VEL = 2'd1,
    CMD_ACC = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]     cmd;
    logic [T_W-1:0] t_param;
  } cse_in_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x_value;
    logic signed [CRD_W-1:0] y_value;
    logic                    saturated;
  } cse_out_t;

  typedef struct packed {
    spline_t              kind;
    logic [3:0][PT_W-1:0] pt;
  } cse_cfg_t;

  // One coordinate in flight: running value and the addends still to apply.
  typedef struct packed {
    logic signed [VW-1:0]         acc;
    logic [NUM_CELLS-1:0][VW-1:0] addend;
  } cse_lane_t;

  typedef struct packed {
    cse_lane_t [1:0] lane;
    logic [T_W-1:0]  t;
    spline_t         kind;
  } cse_tok_t;

endpackage

// ----- rtl/cse_coef.sv -----
// cse_coef.sv: builds the polynomial coefficients from the stored points
// and loads the Horner start value and addends for the selected quantity. Uses cse_pkg.
module cse_coef
  import cse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cse_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  cse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cse_tok_t out_tok
);

  logic     valid;
  cse_tok_t tok;
  cse_tok_t tok_next;

  function automatic cse_lane_t build_lane(
    input spline_t                 kind,
    input logic [1:0]              cmd,
    input logic signed [CRD_W-1:0] p0,
    input logic signed [CRD_W-1:0] p1,
    input logic signed [CRD_W-1:0] p2,
    input logic signed [CRD_W-1:0] p3
  );
    logic signed [CW-1:0] s0, s1, s2, s3;
    logic signed [CW-1:0] c0, c1, c2, c3;
    logic signed [VW-1:0] w0, w1, w2, w3;
    cse_lane_t            r;
    s0 = {{(CW-CRD_W){p0[CRD_W-1]}}, p0};
    s1 = {{(CW-CRD_W){p1[CRD_W-1]}}, p1};
    s2 = {{(CW-CRD_W){p2[CRD_W-1]}}, p2};
    s3 = {{(CW-CRD_W){p3[CRD_W-1]}}, p3};
    // Hermite handles become tangents relative to their anchor points
    if (kind == SPL_HERMITE) begin
      s1 = s1 - s0;
      s3 = s3 - s2;
    end
    case (kind)
      SPL_BEZIER: begin
        c0 = s0;
        c1 = 3 * s1 - 3 * s0;
        c2 = 3 * s0 - 6 * s1 + 3 * s2;
        c3 = 3 * s1 - s0 - 3 * s2 + s3;
      end
      SPL_HERMITE: begin
        c0 = s0;
        c1 = s1;
        c2 = 3 * s2 - 3 * s0 - 2 * s1 - s3;
        c3 = 2 * s0 + s1 - 2 * s2 + s3;
      end
      SPL_CATMULL: begin
        c0 = 2 * s1;
        c1 = s2 - s0;
        c2 = 2 * s0 - 5 * s1 + 4 * s2 - s3;
        c3 = 3 * s1 - s0 - 3 * s2 + s3;
      end
      SPL_BSPLINE: begin
        c0 = s0 + 4 * s1 + s2;
        c1 = 3 * s2 - 3 * s0;
        c2 = 3 * s0 - 6 * s1 + 3 * s2;
        c3 = 3 * s1 - s0 - 3 * s2 + s3;
      end
      default: begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
      end
    endcase
    w0 = {{(VW-CW){c0[CW-1]}}, c0};
    w1 = {{(VW-CW){c1[CW-1]}}, c1};
    w2 = {{(VW-CW){c2[CW-1]}}, c2};
    w3 = {{(VW-CW){c3[CW-1]}}, c3};
    r.acc    = '0;
    r.addend = '0;
    // Start value of zero passes through a cell unchanged, so shorter
    // derivative polynomials simply lead with zero or a leading term.
    case (cmd)
      CMD_POS: begin
        r.acc       = w3;
        r.addend[0] = w2;
        r.addend[1] = w1;
        r.addend[2] = w0;
      end
      CMD_VEL: begin
        r.addend[0] = 3 * w3;
        r.addend[1] = 2 * w2;
        r.addend[2] = w1;
      end
      CMD_ACC: begin
        r.addend[1] = 6 * w3;
        r.addend[2] = 2 * w2;
      end
      default: begin
        r.acc    = '0;
        r.addend = '0;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    tok_next.lane[0] = build_lane(cfg.kind, in_data.cmd,
                                  cfg.pt[0][CRD_W-1:0], cfg.pt[1][CRD_W-1:0],
                                  cfg.pt[2][CRD_W-1:0], cfg.pt[3][CRD_W-1:0]);
    tok_next.lane[1] = build_lane(cfg.kind, in_data.cmd,
                                  cfg.pt[0][PT_W-1:CRD_W], cfg.pt[1][PT_W-1:CRD_W],
                                  cfg.pt[2][PT_W-1:CRD_W], cfg.pt[3][PT_W-1:CRD_W]);
    tok_next.t    = in_data.t_param;
    tok_next.kind = cfg.kind;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_tok   = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok <= tok_next;
    end
  end

endmodule

// ----- rtl/cse_cell.sv -----
// cse_cell.sv: one Horner step, acc = addend + round(acc * t / 2^T_BITS),
// as a split multiply stage followed by an add stage. Uses cse_pkg.
module cse_cell
  import cse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cse_tok_t in_tok,
  output logic     out_valid,
  input  logic     out_ready,
  output cse_tok_t out_tok
);

  localparam int PLW = LO_W + T_W;
  localparam int PHW = HI_W + T_W + 1;
  localparam int SH  = LO_W - T_BITS;
  localparam logic [PLW-1:0] RND = PLW'(1) << (T_BITS - 1);

  logic                  mul_valid;
  logic                  mul_ready;
  logic                  add_valid;
  cse_tok_t              mul_tok;
  cse_tok_t              add_tok;
  cse_tok_t              add_tok_next;
  logic [PLW-1:0]        lo_prod   [2];
  logic [PLW-1:0]        p_lo_next [2];
  logic [PLW-1:0]        p_lo      [2];
  logic signed [PHW-1:0] p_hi_next [2];
  logic signed [PHW-1:0] p_hi      [2];
  logic signed [VW-1:0]  hi_ext    [2];
  logic signed [VW-1:0]  lo_ext    [2];

  // Split multiply: unsigned low slice and signed high slice, rounding
  // constant folded into the low product.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lo_prod[i]   = in_tok.lane[i].acc[LO_W-1:0] * in_tok.t;
      p_lo_next[i] = lo_prod[i] + RND;
      p_hi_next[i] = $signed(in_tok.lane[i].acc[VW-1:LO_W]) * $signed({1'b0, in_tok.t});
    end
  end

  // Recombine, drop fraction bits, add this step's addend, shift the list.
  always_comb begin
    add_tok_next = mul_tok;
    for (int i = 0; i < 2; i++) begin
      hi_ext[i] = {{(VW-PHW){p_hi[i][PHW-1]}}, p_hi[i]};
      lo_ext[i] = {{(VW-PLW+T_BITS){1'b0}}, p_lo[i][PLW-1:T_BITS]};
      add_tok_next.lane[i].acc = $signed(mul_tok.lane[i].addend[0])
                                 + (hi_ext[i] <<< SH) + lo_ext[i];
      for (int k = 0; k < NUM_CELLS - 1; k++) begin
        add_tok_next.lane[i].addend[k] = mul_tok.lane[i].addend[k+1];
      end
      add_tok_next.lane[i].addend[NUM_CELLS-1] = '0;
    end
  end

  assign mul_ready = !add_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;
  assign out_valid = add_valid;
  assign out_tok   = add_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      add_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid <= in_valid;
      end
      if (mul_ready) begin
        add_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_tok <= in_tok;
      p_lo    <= p_lo_next;
      p_hi    <= p_hi_next;
    end
    if (mul_ready && mul_valid) begin
      add_tok <= add_tok_next;
    end
  end

endmodule

// ----- rtl/cse_norm.sv -----
// cse_norm.sv: rounds the Horner result by the basis divisor (1, 2 or 6),
// saturates both coordinates and holds the response register. Uses cse_pkg.
module cse_norm
  import cse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cse_tok_t in_tok,
  output logic     out_valid,
  input  logic     out_ready,
  output cse_out_t out_data
);

  localparam int UW     = VW - 1;
  localparam int UH_W   = UW - DIV_SPLIT;
  localparam int K1_W   = DIV_SPLIT - 1;
  localparam int K2_W   = DIV_SPLIT + 2;
  localparam int RSH    = DIV_SPLIT + 3;
  localparam int SUM_W  = DIV_SPLIT + 1;
  localparam int PL_W   = SUM_W + K2_W;
  localparam int QH_W   = UH_W + K1_W;
  localparam logic [K1_W-1:0] K1 = K1_W'((2**DIV_SPLIT - 1) / 3);
  localparam logic [K2_W-1:0] K2 = K2_W'((2**RSH + 2) / 3);
  localparam logic signed [VW-1:0] ONE       = 1;
  localparam logic signed [VW-1:0] TWO       = 2;
  localparam logic signed [VW-1:0] THREE     = 3;
  localparam logic signed [VW-1:0] NEG_THREE = -3;
  localparam logic signed [VW-1:0] MAXV = {{(VW-CRD_W+1){1'b0}}, {(CRD_W-1){1'b1}}};
  localparam logic signed [VW-1:0] MINV = {{(VW-CRD_W+1){1'b1}}, {(CRD_W-1){1'b0}}};

  logic                 red_valid, mul_valid, fin_valid;
  logic                 mul_ready, fin_ready;
  spline_t              red_kind, mul_kind;
  logic                 neg_next    [2];
  logic                 red_neg     [2];
  logic                 mul_neg     [2];
  logic [VW-1:0]        mag         [2];
  logic [UW-1:0]        u_next      [2];
  logic [UW-1:0]        red_u       [2];
  logic signed [VW-1:0] simple_next [2];
  logic signed [VW-1:0] red_simple  [2];
  logic signed [VW-1:0] mul_simple  [2];
  logic [SUM_W-1:0]     fold        [2];
  logic [QH_W-1:0]      qh_next     [2];
  logic [QH_W-1:0]      mul_qh      [2];
  logic [PL_W-1:0]      pl          [2];
  logic [DIV_SPLIT-1:0] mul_ql      [2];
  logic signed [VW-1:0] quot        [2];
  logic signed [VW-1:0] res         [2];
  logic signed [CRD_W-1:0] clip     [2];
  logic                 clipped     [2];
  cse_out_t             rsp;
  cse_out_t             rsp_next;

  // Divide by six: floor((v+3)/6), taken on a magnitude so the quotient
  // is always a floor of a nonnegative value, then halved.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      neg_next[i] = in_tok.lane[i].acc < NEG_THREE;
      mag[i]      = neg_next[i] ? (TWO - in_tok.lane[i].acc) : (in_tok.lane[i].acc + THREE);
      u_next[i]   = mag[i][VW-1:1];
      case (in_tok.kind)
        SPL_CATMULL: simple_next[i] = (in_tok.lane[i].acc + ONE) >>> 1;
        default:     simple_next[i] = in_tok.lane[i].acc;
      endcase
    end
  end

  // Divide by three: since 2^DIV_SPLIT leaves remainder one, fold the high
  // part onto the low part and divide the small sum by a reciprocal.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fold[i]    = {{(SUM_W-UH_W){1'b0}}, red_u[i][UW-1:DIV_SPLIT]}
                   + {1'b0, red_u[i][DIV_SPLIT-1:0]};
      qh_next[i] = red_u[i][UW-1:DIV_SPLIT] * K1;
      pl[i]      = fold[i] * K2;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      quot[i] = $signed({{(VW-QH_W){1'b0}}, mul_qh[i]})
                + $signed({{(VW-DIV_SPLIT){1'b0}}, mul_ql[i]});
      if (mul_kind == SPL_BSPLINE) begin
        res[i] = mul_neg[i] ? -quot[i] : quot[i];
      end else begin
        res[i] = mul_simple[i];
      end
      if (res[i] > MAXV) begin
        clip[i]    = MAXV[CRD_W-1:0];
        clipped[i] = 1'b1;
      end else if (res[i] < MINV) begin
        clip[i]    = MINV[CRD_W-1:0];
        clipped[i] = 1'b1;
      end else begin
        clip[i]    = res[i][CRD_W-1:0];
        clipped[i] = 1'b0;
      end
    end
    rsp_next.x_value   = clip[0];
    rsp_next.y_value   = clip[1];
    rsp_next.saturated = clipped[0] || clipped[1];
  end

  assign fin_ready = !fin_valid || out_ready;
  assign mul_ready = !mul_valid || fin_ready;
  assign in_ready  = !red_valid || mul_ready;
  assign out_valid = fin_valid;
  assign out_data  = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_valid <= 1'b0;
      mul_valid <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        red_valid <= in_valid;
      end
      if (mul_ready) begin
        mul_valid <= red_valid;
      end
      if (fin_ready) begin
        fin_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red_kind   <= in_tok.kind;
      red_neg    <= neg_next;
      red_u      <= u_next;
      red_simple <= simple_next;
    end
    if (mul_ready && red_valid) begin
      mul_kind   <= red_kind;
      mul_neg    <= red_neg;
      mul_simple <= red_simple;
      mul_qh     <= qh_next;
      for (int i = 0; i < 2; i++) begin
        mul_ql[i] <= pl[i][PL_W-1:RSH];
      end
    end
    if (fin_ready && mul_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/cubic_spline_evaluator_unit.sv -----
// cubic_spline_evaluator_unit: 2-D cubic spline segment evaluator, top level.
// From request to response: one coefficient stage, two stages in
// each of three Horner cells (split multiply, then add), three normalize stages.
// One transaction per cycle unless stalled; every cell owns its multipliers.
// rst (synchronous) empties the pipeline and sets Bezier with all points zero.
module cubic_spline_evaluator_unit
  import cse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [PT_W-1:0]      cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cse_in_t              req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cse_out_t             rsp_data
);

  cse_cfg_t cfg;

  // Handshake chain: index 0 is the coefficient stage output, index
  // NUM_CELLS the last cell output feeding the normalizer.
  logic     chain_valid [NUM_CELLS+1];
  logic     chain_ready [NUM_CELLS+1];
  cse_tok_t chain_tok   [NUM_CELLS+1];

  // Configuration registers, read directly by the coefficient stage. Writes must
  // land only while idle; the block does not enforce it. Drop writes beyond the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind <= SPL_BEZIER;
      cfg.pt   <= '0;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_TYPE: cfg.kind  <= spline_t'(cfg_wdata[1:0]);
        REG_P0:   cfg.pt[0] <= cfg_wdata;
        REG_P1:   cfg.pt[1] <= cfg_wdata;
        REG_P2:   cfg.pt[2] <= cfg_wdata;
        REG_P3:   cfg.pt[3] <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Coefficients C = M * S and the start value / addends for the
  // selected quantity; a fourth command code evaluates to zero.
  cse_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_data   (req_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_tok   (chain_tok[0])
  );

  // Row of Horner cells. Each applies one multiply-by-t and add, then
  // hands the shortened addend list to its neighbor. A stage that holds
  // a bubble still accepts, so the chain fills while the response stalls.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    cse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_tok    (chain_tok[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_tok   (chain_tok[g+1])
    );
  end

  // Divide by the basis divisor with round half up, saturate, and hold
  // the response register until it is taken.
  cse_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NUM_CELLS]),
    .in_ready  (chain_ready[NUM_CELLS]),
    .in_tok    (chain_tok[NUM_CELLS]),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .out_data  (rsp_data)
  );

endmodule

// ----- rtl/cse_checker.sv -----
// cse_checker.sv: port-level assertions for cubic_spline_evaluator_unit,
// attached by the bind at the end of this file. Uses cse_pkg.
module cse_checker
  import cse_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_wen,
  input logic [CFG_IDX_W-1:0] cfg_idx,
  input logic [PT_W-1:0]      cfg_wdata,
  input logic                 req_valid,
  input logic                 req_ready,
  input cse_in_t              req_data,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input cse_out_t             rsp_data
);

  localparam logic signed [CRD_W-1:0] MAXV = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] MINV = {1'b1, {(CRD_W-1){1'b0}}};

  // Reset must empty the response register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // With the output free, every stage can advance, so requests are taken.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("request stalled while response side is free");

  // A stalled response must hold.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // The clip flag implies a coordinate sits at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.saturated |->
      rsp_data.x_value == MAXV || rsp_data.x_value == MINV ||
      rsp_data.y_value == MAXV || rsp_data.y_value == MINV)
    else $error("saturated set without a clipped coordinate");

endmodule

bind cubic_spline_evaluator_unit cse_checker u_cse_checker (.*);
